// ===== sv/wkb_geometry_stream_parser_defines.svh =====
// ----------------------------------------------------------------------------
// wkb_geometry_stream_parser_defines
// assertion macros shared by the parser rtl
// ----------------------------------------------------------------------------
`ifndef WKB_GEOMETRY_STREAM_PARSER_DEFINES_SVH
`define WKB_GEOMETRY_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define WKB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wkb assertion failed");

// next-cycle implication
`define WKB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wkb assertion failed");

`endif

// ===== sv/wkb_pkg.sv =====
// ----------------------------------------------------------------------------
// wkb_pkg
// types and codes shared by the wkb geometry parser
// ----------------------------------------------------------------------------
`default_nettype none
package wkb_pkg;

	localparam int NEST_DEPTH_DEF = 8;

	typedef enum logic [3:0] {
		PH_ORDER   = 4'd0,
		PH_TYPE    = 4'd1,
		PH_COUNT   = 4'd2,
		PH_NRINGS  = 4'd3,
		PH_NPOINTS = 4'd4,
		PH_X       = 4'd5,
		PH_Y       = 4'd6,
		PH_DONE    = 4'd7
	} phase_t;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_ORDER = 3'd1;
	localparam logic [2:0] ERR_TYPE  = 3'd2;
	localparam logic [2:0] ERR_DEEP  = 3'd3;
	localparam logic [2:0] ERR_CUT   = 3'd4;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_POLY  = 2'd2;

	localparam logic [31:0] T_POINT  = 32'd1;
	localparam logic [31:0] T_LINE   = 32'd2;
	localparam logic [31:0] T_POLY   = 32'd3;
	localparam logic [31:0] T_MPOINT = 32'd4;
	localparam logic [31:0] T_MLINE  = 32'd5;
	localparam logic [31:0] T_MPOLY  = 32'd6;
	localparam logic [31:0] T_COLL   = 32'd7;

	localparam logic [7:0] BO_BIG    = 8'd0;
	localparam logic [7:0] BO_LITTLE = 8'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       record_start;
	} rec_t;

	typedef struct packed {
		logic        vertex_valid;
		logic [1:0]  shape_kind;
		logic [15:0] geometry_number;
		logic [63:0] x_bits;
		logic [63:0] y_bits;
		logic        geometry_end;
		logic        record_end;
		logic [2:0]  error_code;
	} res_t;

	// float64 equality: nan never equal, signed zeros equal
	function automatic logic f64_eq(input logic [63:0] a, input logic [63:0] b);
		logic an;
		logic bn;
		an = a[62:0] > 63'h7FF0000000000000;
		bn = b[62:0] > 63'h7FF0000000000000;
		if (an || bn) return 1'b0;
		if (a[62:0] == 63'd0 && b[62:0] == 63'd0) return 1'b1;
		return a == b;
	endfunction

endpackage
`default_nettype wire

// ===== sv/wkb_ram.sv =====
// ----------------------------------------------------------------------------
// wkb_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module wkb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/wkb_geometry_stream_parser.sv =====
// ----------------------------------------------------------------------------
// wkb_geometry_stream_parser
// byte-serial well-known-binary geometry parser with vertex dedup
// ----------------------------------------------------------------------------
// usage
// - rec channel: one record byte per request, record_start on the first byte
//   of each record; rec_stall is raised only while a result sits unread in
//   the output register and the receiver stalls it
// - res channel: zero or one result per byte (vertex, geometry end, record
//   end or error); held steady in the output register while res_stall is high
// - latency: a result is visible the cycle after its byte is taken
// - throughput: one byte per cycle while rec_stall is low, set by the single
//   parse step on the byte counters and the nesting stack top
// - the child counts of the nesting stack live in a small ram; a completed
//   child reads the surviving level and writes it back decremented on the
//   next cycle, which always ends before that level is needed again
// - reset (arst_n low) returns to awaiting a byte-order byte with an empty
//   output register; record_start restarts parsing the same way
// - after an error nothing is reported until the next record_start
// ----------------------------------------------------------------------------
`default_nettype none
`include "wkb_geometry_stream_parser_defines.svh"
module wkb_geometry_stream_parser #(
	parameter int NEST_DEPTH = wkb_pkg::NEST_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rec_valid,
	output      logic          rec_stall,
	input  wire wkb_pkg::rec_t rec,
	output      logic          res_valid,
	input  wire logic          res_stall,
	output      wkb_pkg::res_t res
);
	localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	localparam int TW = $clog2(NEST_DEPTH + 1);

	// parse state
	wkb_pkg::phase_t phase_q;
	logic [2:0]            pos_q;
	logic [63:0]           asm_q;
	logic [63:0]           held_x_q;
	logic [63:0]           prev_x_q;
	logic [63:0]           prev_y_q;
	logic                  prev_ok_q;
	logic                  be_q;
	logic [TW-1:0]         top_q;
	logic [NEST_DEPTH-1:0] one_q;     // level count equals one
	logic [31:0]           rings_q;
	logic [31:0]           points_q;
	logic [15:0]           gcnt_q;
	logic                  err_q;
	logic [1:0]            kind_q;

	// stack writeback after a completed child
	logic          wb_pend_q;
	logic [AW-1:0] wb_idx_q;
	logic [31:0]   ram_rdata;

	logic res_valid_q;
	wkb_pkg::res_t res_q;

	logic acc;
	assign rec_stall = res_valid_q & res_stall;
	assign acc = rec_valid & ~rec_stall;

	// state seen by the byte, after a restart if record_start is set
	wkb_pkg::phase_t c_phase;
	logic [2:0]            c_pos;
	logic [63:0]           c_asm;
	logic [63:0]           c_held;
	logic [63:0]           c_px;
	logic [63:0]           c_py;
	logic                  c_pok;
	logic                  c_be;
	logic [TW-1:0]         c_top;
	logic [NEST_DEPTH-1:0] c_one;
	logic [31:0]           c_rings;
	logic [31:0]           c_points;
	logic [15:0]           c_gcnt;
	logic                  c_err;
	logic [1:0]            c_kind;

	always_comb begin
		if (rec.record_start) begin
			c_phase = wkb_pkg::PH_ORDER; c_pos = '0; c_asm = '0; c_held = '0;
			c_px = '0; c_py = '0; c_pok = 1'b0; c_be = 1'b0; c_top = '0;
			c_one = '0; c_rings = '0; c_points = '0; c_gcnt = '0;
			c_err = 1'b0; c_kind = wkb_pkg::KIND_POINT;
		end else begin
			c_phase = phase_q; c_pos = pos_q; c_asm = asm_q; c_held = held_x_q;
			c_px = prev_x_q; c_py = prev_y_q; c_pok = prev_ok_q; c_be = be_q;
			c_top = top_q; c_one = one_q; c_rings = rings_q; c_points = points_q;
			c_gcnt = gcnt_q; c_err = err_q; c_kind = kind_q;
		end
	end

	// unwind: highest live level whose count stays above zero
	logic          fin_found;
	logic [AW-1:0] fin_idx;
	always_comb begin
		fin_found = 1'b0;
		fin_idx = '0;
		for (int i = 0; i < NEST_DEPTH; i++) begin
			if (TW'(i) < c_top && !c_one[i]) begin
				fin_found = 1'b1;
				fin_idx = AW'(i);
			end
		end
	end

	// next state and result
	wkb_pkg::phase_t n_phase;
	logic [2:0]            n_pos;
	logic [63:0]           n_asm;
	logic [63:0]           n_held;
	logic [63:0]           n_px;
	logic [63:0]           n_py;
	logic                  n_pok;
	logic                  n_be;
	logic [TW-1:0]         n_top;
	logic [NEST_DEPTH-1:0] n_one;
	logic [31:0]           n_rings;
	logic [31:0]           n_points;
	logic [15:0]           n_gcnt;
	logic                  n_err;
	logic [1:0]            n_kind;
	logic                  r_v;
	wkb_pkg::res_t r_d;
	logic                  push_we;
	logic [AW-1:0]         push_idx;
	logic [31:0]           push_val;
	logic                  fin_go;

	logic [63:0] asm_new;
	logic        last;
	logic [31:0] v32;
	logic        keep;
	logic        do_ring;
	logic        do_geom;
	logic        g_keep;
	logic [31:0] rings_dec;
	logic [31:0] points_dec;

	always_comb begin
		n_phase = c_phase; n_pos = c_pos; n_asm = c_asm; n_held = c_held;
		n_px = c_px; n_py = c_py; n_pok = c_pok; n_be = c_be; n_top = c_top;
		n_one = c_one; n_rings = c_rings; n_points = c_points; n_gcnt = c_gcnt;
		n_err = c_err; n_kind = c_kind;
		r_v = 1'b0; r_d = '0;
		push_we = 1'b0; push_idx = c_top[AW-1:0]; push_val = '0;
		fin_go = 1'b0;
		do_ring = 1'b0; do_geom = 1'b0; g_keep = 1'b0; keep = 1'b0;
		rings_dec = c_rings - 32'd1;
		points_dec = c_points - 32'd1;

		if (c_be) asm_new = {c_asm[55:0], rec.data_byte};
		else asm_new = c_asm | ({56'd0, rec.data_byte} << {c_pos, 3'b000});
		if (c_phase == wkb_pkg::PH_X || c_phase == wkb_pkg::PH_Y) last = (c_pos == 3'd7);
		else last = (c_pos == 3'd3);
		v32 = asm_new[31:0];

		// record cut short
		if (rec.record_start && !err_q && phase_q != wkb_pkg::PH_DONE
			&& !(phase_q == wkb_pkg::PH_ORDER && top_q == '0)) begin
			r_v = 1'b1;
			r_d.geometry_number = gcnt_q;
			r_d.error_code = wkb_pkg::ERR_CUT;
		end

		if (!c_err && c_phase != wkb_pkg::PH_DONE) begin
			if (c_phase == wkb_pkg::PH_ORDER) begin
				if (rec.data_byte == wkb_pkg::BO_BIG || rec.data_byte == wkb_pkg::BO_LITTLE) begin
					n_be = (rec.data_byte == wkb_pkg::BO_BIG);
					n_phase = wkb_pkg::PH_TYPE;
					n_pos = '0;
					n_asm = '0;
				end else begin
					n_err = 1'b1;
					if (!r_v) begin
						r_v = 1'b1;
						r_d.geometry_number = c_gcnt;
						r_d.error_code = wkb_pkg::ERR_ORDER;
					end
				end
			end else if (!last) begin
				n_pos = c_pos + 3'd1;
				n_asm = asm_new;
			end else begin
				n_pos = '0;
				n_asm = '0;
				unique case (c_phase)
					wkb_pkg::PH_TYPE: begin
						if (v32 == wkb_pkg::T_POINT) begin
							n_kind = wkb_pkg::KIND_POINT; n_rings = 32'd1; n_points = 32'd1;
							n_pok = 1'b0; n_phase = wkb_pkg::PH_X;
						end else if (v32 == wkb_pkg::T_LINE) begin
							n_kind = wkb_pkg::KIND_LINE; n_rings = 32'd1;
							n_pok = 1'b0; n_phase = wkb_pkg::PH_NPOINTS;
						end else if (v32 == wkb_pkg::T_POLY) begin
							n_kind = wkb_pkg::KIND_POLY;
							n_pok = 1'b0; n_phase = wkb_pkg::PH_NRINGS;
						end else if (v32 == wkb_pkg::T_MPOINT || v32 == wkb_pkg::T_MLINE
							|| v32 == wkb_pkg::T_MPOLY || v32 == wkb_pkg::T_COLL) begin
							n_phase = wkb_pkg::PH_COUNT;
						end else begin
							n_err = 1'b1; r_v = 1'b1;
							r_d.geometry_number = c_gcnt;
							r_d.error_code = wkb_pkg::ERR_TYPE;
						end
					end
					wkb_pkg::PH_COUNT: begin
						if (v32 == 32'd0) begin
							// empty container completes at once
							if (fin_found) begin
								n_top = TW'(fin_idx) + TW'(1);
								n_phase = wkb_pkg::PH_ORDER;
								fin_go = 1'b1;
							end else begin
								n_top = '0;
								n_phase = wkb_pkg::PH_DONE;
								r_v = 1'b1;
								r_d.geometry_number = c_gcnt;
								r_d.record_end = 1'b1;
							end
						end else if (c_top >= TW'(NEST_DEPTH)) begin
							n_err = 1'b1; r_v = 1'b1;
							r_d.geometry_number = c_gcnt;
							r_d.error_code = wkb_pkg::ERR_DEEP;
						end else begin
							push_we = 1'b1;
							push_val = v32;
							n_one[c_top[AW-1:0]] = (v32 == 32'd1);
							n_top = c_top + TW'(1);
							n_phase = wkb_pkg::PH_ORDER;
						end
					end
					wkb_pkg::PH_NRINGS: begin
						n_rings = v32;
						if (v32 == 32'd0) do_geom = 1'b1;
						else n_phase = wkb_pkg::PH_NPOINTS;
					end
					wkb_pkg::PH_NPOINTS: begin
						n_points = v32;
						if (v32 == 32'd0) do_ring = 1'b1;
						else n_phase = wkb_pkg::PH_X;
					end
					wkb_pkg::PH_X: begin
						n_held = asm_new;
						n_phase = wkb_pkg::PH_Y;
					end
					wkb_pkg::PH_Y: begin
						keep = !(c_pok && wkb_pkg::f64_eq(c_held, c_px)
							&& wkb_pkg::f64_eq(asm_new, c_py));
						if (keep) begin
							n_px = c_held; n_py = asm_new; n_pok = 1'b1;
						end
						n_points = points_dec;
						if (points_dec != 32'd0) begin
							n_phase = wkb_pkg::PH_X;
							if (keep) begin
								r_v = 1'b1;
								r_d.vertex_valid = 1'b1;
								r_d.shape_kind = c_kind;
								r_d.geometry_number = c_gcnt;
								r_d.x_bits = c_held;
								r_d.y_bits = asm_new;
							end
						end else begin
							do_ring = 1'b1;
						end
					end
					default: ;
				endcase

				// ring complete
				if (do_ring) begin
					n_rings = rings_dec;
					if (rings_dec == 32'd0) begin
						do_geom = 1'b1;
						g_keep = keep;
					end else begin
						n_phase = wkb_pkg::PH_NPOINTS;
						if (keep) begin
							r_v = 1'b1;
							r_d.vertex_valid = 1'b1;
							r_d.shape_kind = c_kind;
							r_d.geometry_number = c_gcnt;
							r_d.x_bits = c_held;
							r_d.y_bits = asm_new;
						end
					end
				end

				// simple geometry complete
				if (do_geom) begin
					if (fin_found) begin
						n_top = TW'(fin_idx) + TW'(1);
						n_phase = wkb_pkg::PH_ORDER;
						fin_go = 1'b1;
					end else begin
						n_top = '0;
						n_phase = wkb_pkg::PH_DONE;
					end
					r_v = 1'b1;
					r_d.vertex_valid = g_keep;
					r_d.shape_kind = c_kind;
					r_d.geometry_number = c_gcnt;
					r_d.x_bits = g_keep ? c_held : 64'd0;
					r_d.y_bits = g_keep ? asm_new : 64'd0;
					r_d.geometry_end = 1'b1;
					r_d.record_end = !fin_found;
					if (c_gcnt != 16'hFFFF) n_gcnt = c_gcnt + 16'd1;
				end
			end
		end
	end

	// child count stack
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	always_comb begin
		if (wb_pend_q) begin
			ram_we = 1'b1;
			ram_waddr = wb_idx_q;
			ram_wdata = ram_rdata - 32'd1;
		end else begin
			ram_we = acc & push_we;
			ram_waddr = push_idx;
			ram_wdata = push_val;
		end
	end

	wkb_ram #(
		.WIDTH(32),
		.DEPTH(NEST_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(fin_idx),
		.rdata(ram_rdata)
	);

	logic [NEST_DEPTH-1:0] one_d;
	always_comb begin
		one_d = acc ? n_one : one_q;
		// surviving level: count after decrement equals one when it was two
		if (wb_pend_q) one_d[wb_idx_q] = (ram_rdata == 32'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wkb_pkg::PH_ORDER;
			pos_q <= '0;
			be_q <= 1'b0;
			top_q <= '0;
			one_q <= '0;
			prev_ok_q <= 1'b0;
			err_q <= 1'b0;
			gcnt_q <= '0;
			kind_q <= wkb_pkg::KIND_POINT;
			rings_q <= '0;
			points_q <= '0;
			wb_pend_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			one_q <= one_d;
			wb_pend_q <= acc & fin_go;
			if (acc) begin
				phase_q <= n_phase;
				pos_q <= n_pos;
				be_q <= n_be;
				top_q <= n_top;
				prev_ok_q <= n_pok;
				err_q <= n_err;
				gcnt_q <= n_gcnt;
				kind_q <= n_kind;
				rings_q <= n_rings;
				points_q <= n_points;
			end
			if (acc && r_v) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		wb_idx_q <= fin_idx;
		if (acc) begin
			asm_q <= n_asm;
			held_x_q <= n_held;
			prev_x_q <= n_px;
			prev_y_q <= n_py;
		end
		if (acc && r_v) res_q <= r_d;
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	// stack pointer never passes the stack size
	`WKB_ASSERT_NOW(a_top_range, 1'b1, top_q <= TW'(NEST_DEPTH))
	// writeback never collides with a push
	`WKB_ASSERT_NOW(a_wb_no_push, wb_pend_q, !(acc && push_we))
	// an error result carries no vertex
	`WKB_ASSERT_NOW(a_err_clean, res_valid && res.error_code != wkb_pkg::ERR_NONE,
		!res.vertex_valid && !res.geometry_end)

endmodule
`default_nettype wire
